// File: src/ifhb_pkg.sv
// Package for the IPv4 fragment header builder.
// Holds the controller state type, the command/status structs and the header constants.
// No dependencies.
package ifhb_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_CHECK,
        ST_FRAG,
        ST_FOLD,
        ST_EMIT
    } ifhb_state_t;

    // upper_protocol codes
    localparam logic [1:0] PROTO_UDP  = 2'd0;
    localparam logic [1:0] PROTO_ICMP = 2'd1;

    // configuration register indexes
    localparam logic CFG_SOURCE_ADDRESS = 1'b0;
    localparam logic CFG_LINK_MTU       = 1'b1;

    localparam logic [10:0] MTU_RESET    = 11'd1500;
    localparam logic [10:0] MTU_MIN      = 11'd148;
    localparam logic [10:0] MTU_MAX      = 11'd1500;
    localparam logic [10:0] HDR_BYTES    = 11'd20;
    localparam logic [15:0] VER_IHL_TOS  = 16'h4500;
    localparam logic [7:0]  TTL_VALUE    = 8'd128;
    localparam logic [7:0]  IPPROTO_UDP  = 8'd17;
    localparam logic [7:0]  IPPROTO_ICMP = 8'd1;

    typedef struct packed {
        logic load_in;   // latch the accepted descriptor
        logic prep;      // clamp MTU, chunk size, base checksum, error checks
        logic check;     // fragment count check, reset fragment cursor
        logic frag;      // compute one fragment's fields and raw sum
        logic fold;      // fold the sum into the output register
        logic advance;   // step the cursor to the next fragment
    } ifhb_cmd_t;

    typedef struct packed {
        logic out_last;  // the result in the output register ends the datagram
    } ifhb_status_t;

endpackage

// File: src/ifhb_ctrl.sv
// Controller state machine for the IPv4 fragment header builder.
// Depends on ifhb_pkg; drives the datapath through ifhb_cmd_t.
module ifhb_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  ifhb_pkg::ifhb_status_t status,
    output ifhb_pkg::ifhb_cmd_t   cmd
);
    import ifhb_pkg::*;

    ifhb_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_PREP;
            end
            ST_PREP:  state_next = ST_CHECK;
            ST_CHECK: state_next = ST_FRAG;
            ST_FRAG:  state_next = ST_FOLD;
            ST_FOLD:  state_next = ST_EMIT;
            ST_EMIT: begin
                if (m_tready) state_next = status.out_last ? ST_IDLE : ST_FRAG;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready    = 1'b0;
        m_tvalid    = 1'b0;
        cmd         = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            ST_PREP:  cmd.prep  = 1'b1;
            ST_CHECK: cmd.check = 1'b1;
            ST_FRAG:  cmd.frag  = 1'b1;
            ST_FOLD:  cmd.fold  = 1'b1;
            ST_EMIT: begin
                m_tvalid    = 1'b1;
                cmd.advance = m_tready && !status.out_last;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

// File: src/ifhb_dp.sv
// Datapath for the IPv4 fragment header builder: configuration registers,
// descriptor latch, fragment cursor, checksum adder and output register. Uses ifhb_pkg.
module ifhb_dp #(
    parameter int MAX_DATAGRAM_BYTES = 8192,
    parameter int MAX_FRAGMENTS      = 64
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    input  logic                   cfg_index,
    input  logic [31:0]            cfg_data,
    input  logic [12:0]            in_payload_length,
    input  logic [1:0]             in_upper_protocol,
    input  logic [31:0]            in_destination_address,
    input  logic [15:0]            in_identification,
    input  ifhb_pkg::ifhb_cmd_t    cmd,
    output ifhb_pkg::ifhb_status_t status,
    output logic [10:0]            out_total_length,
    output logic [9:0]             out_fragment_offset,
    output logic                   out_more_fragments,
    output logic [15:0]            out_header_checksum,
    output logic                   out_error,
    output logic                   out_last
);
    import ifhb_pkg::*;

    localparam logic [16:0] MAX_BYTES = 17'(MAX_DATAGRAM_BYTES);
    localparam logic [6:0]  MAX_FRAGS = 7'(MAX_FRAGMENTS);

    // configuration
    logic [31:0] src_reg;
    logic [10:0] mtu_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_reg <= '0;
            mtu_reg <= MTU_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_SOURCE_ADDRESS: src_reg <= cfg_data;
                CFG_LINK_MTU:       mtu_reg <= cfg_data[10:0];
                default:            src_reg <= src_reg;
            endcase
        end
    end

    // descriptor
    logic [12:0] len_reg;
    logic [1:0]  proto_reg;
    logic [31:0] dst_reg;
    logic [15:0] id_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            len_reg   <= in_payload_length;
            proto_reg <= in_upper_protocol;
            dst_reg   <= in_destination_address;
            id_reg    <= in_identification;
        end
    end

    // per-datagram setup
    logic [10:0] mtu_clamped;
    logic [10:0] chunk_next, chunk_reg;
    logic        single_next, single_reg;
    logic        bad_next, bad_reg;
    logic [18:0] base_next, base_reg;
    logic [7:0]  ipproto;
    logic [13:0] len_hdr;

    always_comb begin
        if (mtu_reg < MTU_MIN)      mtu_clamped = MTU_MIN;
        else if (mtu_reg > MTU_MAX) mtu_clamped = MTU_MAX;
        else                        mtu_clamped = mtu_reg;
        chunk_next  = (mtu_clamped - HDR_BYTES) & ~11'd7;
        len_hdr     = {1'b0, len_reg} + {3'b000, HDR_BYTES};
        single_next = len_hdr <= {3'b000, mtu_clamped};
        ipproto     = (proto_reg == PROTO_UDP) ? IPPROTO_UDP : IPPROTO_ICMP;
        bad_next    = ((proto_reg != PROTO_UDP) && (proto_reg != PROTO_ICMP))
                      || ({3'b000, len_hdr} > MAX_BYTES);
        base_next   = {3'b000, VER_IHL_TOS} + {3'b000, id_reg}
                    + {3'b000, TTL_VALUE, ipproto}
                    + {3'b000, src_reg[31:16]} + {3'b000, src_reg[15:0]}
                    + {3'b000, dst_reg[31:16]} + {3'b000, dst_reg[15:0]};
    end

    always_ff @(posedge aclk) begin
        if (cmd.prep) begin
            chunk_reg  <= chunk_next;
            single_reg <= single_next;
            bad_reg    <= bad_next;
            base_reg   <= base_next;
        end
    end

    // fragment count check and cursor
    logic [17:0] frag_capacity;
    logic        fault_reg;
    logic [12:0] remain_reg;
    logic [9:0]  off_reg;

    assign frag_capacity = MAX_FRAGS * chunk_reg;

    always_ff @(posedge aclk) begin
        if (cmd.check) begin
            fault_reg  <= bad_reg
                       || (!single_reg && ({5'b00000, len_reg} > frag_capacity));
            remain_reg <= len_reg;
            off_reg    <= '0;
        end else if (cmd.advance) begin
            remain_reg <= remain_reg - {2'b00, chunk_reg};
            off_reg    <= off_reg + {2'b00, chunk_reg[10:3]};
        end
    end

    // one fragment: fields and raw header sum
    logic        fin;
    logic [12:0] plen;
    logic [10:0] tlen;
    logic [15:0] flagoff;
    logic [10:0] tlen_reg;
    logic        fin_reg;
    logic [19:0] raw_reg;

    always_comb begin
        fin     = single_reg || (remain_reg <= {2'b00, chunk_reg});
        plen    = fin ? remain_reg : {2'b00, chunk_reg};
        tlen    = plen[10:0] + HDR_BYTES;
        flagoff = {2'b00, !fin, 3'b000, off_reg};
    end

    always_ff @(posedge aclk) begin
        if (cmd.frag) begin
            tlen_reg <= tlen;
            fin_reg  <= fin;
            raw_reg  <= {1'b0, base_reg} + {9'd0, tlen} + {4'd0, flagoff};
        end
    end

    // end-around carry folds, invert, load the output register
    logic [16:0] fold1;
    logic [16:0] fold2;

    always_comb begin
        fold1 = {1'b0, raw_reg[15:0]} + {13'd0, raw_reg[19:16]};
        fold2 = {1'b0, fold1[15:0]} + {16'd0, fold1[16]};
    end

    always_ff @(posedge aclk) begin
        if (cmd.fold) begin
            if (fault_reg) begin
                out_total_length    <= '0;
                out_fragment_offset <= '0;
                out_more_fragments  <= 1'b0;
                out_header_checksum <= '0;
                out_error           <= 1'b1;
                out_last            <= 1'b1;
            end else begin
                out_total_length    <= tlen_reg;
                out_fragment_offset <= off_reg;
                out_more_fragments  <= !fin_reg;
                out_header_checksum <= ~fold2[15:0];
                out_error           <= 1'b0;
                out_last            <= fin_reg;
            end
        end
    end

    assign status.out_last = out_last;

endmodule

// File: src/ipv4_fragment_header_builder_unit.sv
// Top level of the IPv4 fragment header builder.
// Instantiates ifhb_ctrl and ifhb_dp; uses ifhb_pkg.
//
// Usage:
//   s_* channel: one transaction per datagram descriptor. s_tdata carries the
//   payload length, destination address and identification; s_tuser carries
//   the upper-protocol code (UDP, ICMP, others rejected).
//   m_* channel: one transaction per fragment header descriptor (total
//   length, offset in 8-byte units, more-fragments, header checksum).
//   m_tuser flags a rejected datagram; m_tlast marks its final descriptor.
//   cfg_* channel: always ready; index 0 writes the source address, index 1
//   the link MTU (clamped into 148..1500 when used). Write only while idle.
// Sequence: one datagram at a time. After the descriptor transaction, the
//   setup steps (MTU clamp, chunk size and base sum, then fragment-count
//   check), then per fragment the sum, fold and present steps, repeated as
//   the controller steps the fragment cursor through the datagram. Rejected
//   datagrams give one result.
// Reset: control returns to idle, source address clears, MTU returns to 1500.
// Stall: when m_tready is low the result is held in the output register and
//   the fragment cursor does not advance; s_tready stays low until the last
//   result of the current datagram is taken.
module ipv4_fragment_header_builder_unit #(
    parameter int MAX_DATAGRAM_BYTES = 8192,
    parameter int MAX_FRAGMENTS      = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    // datagram descriptors
    input  logic        s_tvalid,
    output logic        s_tready,
    // [12:0] payload_length, [44:13] destination_address,
    // [60:45] identification, [63:61] zero
    input  logic [63:0] s_tdata,
    // [1:0] upper_protocol
    input  logic [1:0]  s_tuser,
    // fragment header descriptors
    output logic        m_tvalid,
    input  logic        m_tready,
    // [10:0] total_length, [20:11] fragment_offset, [21] more_fragments,
    // [37:22] header_checksum, [39:38] zero
    output logic [39:0] m_tdata,
    // [0] error
    output logic        m_tuser,
    output logic        m_tlast
);
    import ifhb_pkg::*;

    ifhb_cmd_t    cmd;
    ifhb_status_t status;

    logic [10:0] total_length;
    logic [9:0]  fragment_offset;
    logic        more_fragments;
    logic [15:0] header_checksum;

    // registers accept a write in any cycle
    assign cfg_ready = 1'b1;

    ifhb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ifhb_dp #(
        .MAX_DATAGRAM_BYTES (MAX_DATAGRAM_BYTES),
        .MAX_FRAGMENTS      (MAX_FRAGMENTS)
    ) u_dp (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .cfg_valid              (cfg_valid),
        .cfg_index              (cfg_index),
        .cfg_data               (cfg_data),
        .in_payload_length      (s_tdata[12:0]),
        .in_upper_protocol      (s_tuser),
        .in_destination_address (s_tdata[44:13]),
        .in_identification      (s_tdata[60:45]),
        .cmd                    (cmd),
        .status                 (status),
        .out_total_length       (total_length),
        .out_fragment_offset    (fragment_offset),
        .out_more_fragments     (more_fragments),
        .out_header_checksum    (header_checksum),
        .out_error              (m_tuser),
        .out_last               (m_tlast)
    );

    // pack the result fields, lowest first
    assign m_tdata = {2'b00, header_checksum, more_fragments, fragment_offset, total_length};

endmodule
